[hdl/gblur_pkg.sv]
// Shared constants, types and helper functions for the streaming 3x3 Gaussian blur.
package gblur_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int PIX_W        = 16;
    localparam int COEF_W       = 16;
    localparam int FRAC_W       = 16;
    localparam int WIDTH_CFG_W  = 11;
    localparam int HEIGHT_CFG_W = 13;
    localparam int WCMP_W       = (COL_W + 1 > WIDTH_CFG_W) ? COL_W + 1 : WIDTH_CFG_W;
    localparam int HCMP_W       = (ROW_W + 1 > HEIGHT_CFG_W) ? ROW_W + 1 : HEIGHT_CFG_W;
    localparam int PROD_W       = PIX_W + COEF_W;
    localparam int GRP_W        = PROD_W + 2;
    localparam int SUM_W        = PROD_W + 4;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int FIFO_DEPTH   = 16;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

    localparam logic [PIX_W-1:0]        SAT_LIMIT    = 16'hFF00;
    localparam logic [SUM_W:0]          ROUND_HALF   = (SUM_W + 1)'(1) << (FRAC_W - 1);
    localparam logic [WIDTH_CFG_W-1:0]  RST_WIDTH    = WIDTH_CFG_W'(1024);
    localparam logic [HEIGHT_CFG_W-1:0] RST_HEIGHT   = HEIGHT_CFG_W'(1024);
    localparam logic [COEF_W-1:0]       RST_CENTER   = COEF_W'(16384);
    localparam logic [COEF_W-1:0]       RST_EDGE     = COEF_W'(8192);
    localparam logic [COEF_W-1:0]       RST_CORNER   = COEF_W'(4096);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH,
        REG_HEIGHT,
        REG_CENTER,
        REG_EDGE,
        REG_CORNER
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [2:0][2:0][PIX_W-1:0] win_t;

    typedef struct packed {
        logic             valid;
        logic             due;
        logic             last;
        logic             fwd;
        logic [COL_W-1:0] col;
        logic [2:0]       row_en;
        logic [2:0]       col_en;
    } item_ctl_t;

    typedef struct packed {
        logic       valid;
        logic       last;
        logic [2:0] row_en;
        logic [2:0] col_en;
    } mac_ctl_t;

    function automatic logic [WCMP_W-1:0] eff_width(input logic [WIDTH_CFG_W-1:0] w);
        logic [WCMP_W-1:0] wx;
        wx = WCMP_W'(w);
        if (wx == '0) begin
            return WCMP_W'(1);
        end
        if (wx > WCMP_W'(MAX_WIDTH)) begin
            return WCMP_W'(MAX_WIDTH);
        end
        return wx;
    endfunction

    function automatic logic [HCMP_W-1:0] eff_height(input logic [HEIGHT_CFG_W-1:0] h);
        logic [HCMP_W-1:0] hx;
        hx = HCMP_W'(h);
        if (hx == '0) begin
            return HCMP_W'(1);
        end
        if (hx > HCMP_W'(MAX_HEIGHT)) begin
            return HCMP_W'(MAX_HEIGHT);
        end
        return hx;
    endfunction

endpackage

[hdl/gblur_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module gblur_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/gblur_ctrl.sv]
// Raster position counters, border masks and the first pipeline stage of the blur.
module gblur_ctrl import gblur_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic                    drain,
    input  logic [PIX_W-1:0]        pixel_in,
    input  logic [WIDTH_CFG_W-1:0]  width_cfg,
    input  logic [HEIGHT_CFG_W-1:0] height_cfg,
    output logic                    due,
    output logic                    rd_en,
    output logic [COL_W-1:0]        rd_addr,
    output item_ctl_t               s1_ctl,
    output pix_t                    s1_pix
);

    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [1:0]       in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    item_ctl_t        s1_ctl_reg, s1_ctl_next;
    pix_t             s1_pix_reg;

    logic [WCMP_W-1:0] w_eff;
    logic [HCMP_W-1:0] h_eff;
    logic [COL_W:0]    in_col_inc;
    logic [COL_W:0]    out_col_inc;
    logic [ROW_W:0]    out_row_inc;
    logic              in_wrap;
    logic              out_wrap;
    logic              row_last;
    logic              last;

    always_comb
    begin
        w_eff       = eff_width(width_cfg);
        h_eff       = eff_height(height_cfg);
        in_col_inc  = {1'b0, in_col_reg} + (COL_W + 1)'(1);
        out_col_inc = {1'b0, out_col_reg} + (COL_W + 1)'(1);
        out_row_inc = {1'b0, out_row_reg} + (ROW_W + 1)'(1);
        in_wrap     = WCMP_W'(in_col_inc) >= w_eff;
        out_wrap    = WCMP_W'(out_col_inc) >= w_eff;
        row_last    = HCMP_W'(out_row_inc) >= h_eff;
        last        = row_last && out_wrap;
        due         = (in_row_reg == 2'd2) || ((in_row_reg == 2'd1) && (in_col_reg != '0));

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        if (accept)
        begin
            if (in_wrap)
            begin
                in_col_next = '0;
                if (in_row_reg != 2'd2)
                begin
                    in_row_next = in_row_reg + 2'd1;
                end
            end
            else
            begin
                in_col_next = in_col_inc[COL_W-1:0];
            end

            if (due)
            begin
                if (last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_wrap)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_inc[ROW_W-1:0];
                end
                else
                begin
                    out_col_next = out_col_inc[COL_W-1:0];
                end
            end
        end

        s1_ctl_next.valid  = accept;
        s1_ctl_next.due    = due;
        s1_ctl_next.last   = last;
        s1_ctl_next.fwd    = s1_ctl_reg.valid && (s1_ctl_reg.col == in_col_reg);
        s1_ctl_next.col    = in_col_reg;
        s1_ctl_next.row_en = {!row_last, 1'b1, out_row_reg != '0};
        s1_ctl_next.col_en = {!out_wrap, 1'b1, out_col_reg != '0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            s1_ctl_reg  <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            s1_ctl_reg  <= s1_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= drain ? '0 : pixel_in;
        end
    end

    assign rd_en   = accept;
    assign rd_addr = in_col_reg;
    assign s1_ctl  = s1_ctl_reg;
    assign s1_pix  = s1_pix_reg;

endmodule

[hdl/gblur_line.sv]
// Line store read-modify-write with forwarding and the 3x3 pixel window.
module gblur_line import gblur_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    input  item_ctl_t        s1_ctl,
    input  pix_t             s1_pix,
    output win_t             win,
    output mac_ctl_t         s2_ctl
);

    logic [2*PIX_W-1:0] rd_data;
    logic [2*PIX_W-1:0] wr_data;
    pix_t               older_val;
    pix_t               newer_val;
    pix_t               fwd_older_reg;
    pix_t               fwd_newer_reg;
    win_t               win_reg, win_next;
    mac_ctl_t           s2_ctl_reg, s2_ctl_next;

    gblur_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (s1_ctl.valid),
        .waddr (s1_ctl.col),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        older_val = s1_ctl.fwd ? fwd_older_reg : rd_data[2*PIX_W-1:PIX_W];
        newer_val = s1_ctl.fwd ? fwd_newer_reg : rd_data[PIX_W-1:0];
        wr_data   = {newer_val, s1_pix};

        win_next = win_reg;
        if (s1_ctl.valid)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_next[r][0] = win_reg[r][1];
                win_next[r][1] = win_reg[r][2];
            end
            win_next[0][2] = older_val;
            win_next[1][2] = newer_val;
            win_next[2][2] = s1_pix;
        end

        s2_ctl_next.valid  = s1_ctl.valid && s1_ctl.due;
        s2_ctl_next.last   = s1_ctl.last;
        s2_ctl_next.row_en = s1_ctl.row_en;
        s2_ctl_next.col_en = s1_ctl.col_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= '0;
            s2_ctl_reg <= '0;
        end
        else
        begin
            win_reg    <= win_next;
            s2_ctl_reg <= s2_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ctl.valid)
        begin
            fwd_older_reg <= newer_val;
            fwd_newer_reg <= s1_pix;
        end
    end

    assign win    = win_reg;
    assign s2_ctl = s2_ctl_reg;

endmodule

[hdl/gblur_mac.sv]
// Nine parallel products, a registered adder tree, rounding and saturation.
module gblur_mac import gblur_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  mac_ctl_t          s2_ctl,
    input  win_t              win,
    input  logic [COEF_W-1:0] coef_center,
    input  logic [COEF_W-1:0] coef_edge,
    input  logic [COEF_W-1:0] coef_corner,
    output logic              res_valid,
    output pix_t              res_pixel,
    output logic              res_last
);

    logic [2:0][2:0][PROD_W-1:0] prod_next, prod_reg;
    logic [2:0][GRP_W-1:0]       grp_next, grp_reg;
    logic [SUM_W-1:0]            total_next, total_reg;
    logic [SUM_W:0]              rounded;
    logic [SUM_W-FRAC_W:0]       quot;
    pix_t                        res_next;
    logic                        v3_reg, v4_reg, v5_reg;
    logic                        l3_reg, l4_reg, l5_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                logic [COEF_W-1:0] k;
                pix_t              p;
                if (r == 1 && c == 1)
                begin
                    k = coef_center;
                end
                else if (r == 1 || c == 1)
                begin
                    k = coef_edge;
                end
                else
                begin
                    k = coef_corner;
                end
                p = (s2_ctl.row_en[r] && s2_ctl.col_en[c]) ? win[r][c] : '0;
                prod_next[r][c] = PROD_W'(p) * PROD_W'(k);
            end
        end

        for (int r = 0; r < 3; r++)
        begin
            grp_next[r] = GRP_W'(prod_reg[r][0]) + GRP_W'(prod_reg[r][1])
                        + GRP_W'(prod_reg[r][2]);
        end

        total_next = SUM_W'(grp_reg[0]) + SUM_W'(grp_reg[1]) + SUM_W'(grp_reg[2]);

        rounded  = {1'b0, total_reg} + ROUND_HALF;
        quot     = rounded[SUM_W:FRAC_W];
        res_next = (quot > (SUM_W - FRAC_W + 1)'(SAT_LIMIT)) ? SAT_LIMIT : quot[PIX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= s2_ctl.valid;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        grp_reg   <= grp_next;
        total_reg <= total_next;
        l3_reg    <= s2_ctl.last;
        l4_reg    <= l3_reg;
        l5_reg    <= l4_reg;
    end

    assign res_valid = v5_reg;
    assign res_pixel = res_next;
    assign res_last  = l5_reg;

endmodule

[hdl/gblur_ofifo.sv]
// Output queue with credit tracking so that results in flight always find room.
module gblur_ofifo import gblur_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic reserve,
    input  logic push,
    input  pix_t push_pixel,
    input  logic push_last,
    input  logic out_stall,
    output logic credit_full,
    output logic out_valid,
    output pix_t pixel_out,
    output logic frame_last
);

    pix_t               pix_mem  [FIFO_DEPTH];
    logic               last_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic [FIFO_AW:0]   credit_reg, credit_next;
    logic               pop;

    always_comb
    begin
        pop         = (count_reg != '0) && !out_stall;
        wr_ptr_next = push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;

        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + (FIFO_AW + 1)'(1);
            2'b01:   count_next = count_reg - (FIFO_AW + 1)'(1);
            default: count_next = count_reg;
        endcase

        credit_next = credit_reg;
        case ({reserve, pop})
            2'b10:   credit_next = credit_reg + (FIFO_AW + 1)'(1);
            2'b01:   credit_next = credit_reg - (FIFO_AW + 1)'(1);
            default: credit_next = credit_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            credit_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            credit_reg <= credit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            pix_mem[wr_ptr_reg]  <= push_pixel;
            last_mem[wr_ptr_reg] <= push_last;
        end
    end

    assign credit_full = credit_reg == (FIFO_AW + 1)'(FIFO_DEPTH);
    assign out_valid   = count_reg != '0;
    assign pixel_out   = pix_mem[rd_ptr_reg];
    assign frame_last  = last_mem[rd_ptr_reg];

endmodule

[hdl/gaussian_blur_3x3_stream_top.sv]
// Top level of the streaming 3x3 Gaussian blur with its configuration registers.
// Throughput is one input request per clock while in_stall is low; the line store RAM
// is read and written back once per request, with forwarding when consecutive requests
// hit the same column. A result passes the stage 1, window, product, group-sum, total
// and queue registers; it is one row and one pixel behind its last input in raster order.
// Reset clears all counters, the window and the queue; the line stores are not cleared.
module gaussian_blur_3x3_stream_top import gblur_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIX_W-1:0]      pixel_in,
    input  logic                  drain,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PIX_W-1:0]      pixel_out,
    output logic                  frame_last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [WIDTH_CFG_W-1:0]  width_reg;
    logic [HEIGHT_CFG_W-1:0] height_reg;
    logic [COEF_W-1:0]       center_reg;
    logic [COEF_W-1:0]       edge_reg;
    logic [COEF_W-1:0]       corner_reg;

    logic             accept;
    logic             due;
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
    item_ctl_t        s1_ctl;
    pix_t             s1_pix;
    win_t             win;
    mac_ctl_t         s2_ctl;
    logic             res_valid;
    pix_t             res_pixel;
    logic             res_last;
    logic             credit_full;

    assign cfg_ready = 1'b1;
    assign in_stall  = credit_full;
    assign accept    = in_valid && !credit_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            center_reg <= RST_CENTER;
            edge_reg   <= RST_EDGE;
            corner_reg <= RST_CORNER;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WIDTH:  width_reg  <= cfg_data[WIDTH_CFG_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[HEIGHT_CFG_W-1:0];
                REG_CENTER: center_reg <= cfg_data[COEF_W-1:0];
                REG_EDGE:   edge_reg   <= cfg_data[COEF_W-1:0];
                REG_CORNER: corner_reg <= cfg_data[COEF_W-1:0];
                default:    ;
            endcase
        end
    end

    gblur_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .drain      (drain),
        .pixel_in   (pixel_in),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .due        (due),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .s1_ctl     (s1_ctl),
        .s1_pix     (s1_pix)
    );

    gblur_line u_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .s1_ctl  (s1_ctl),
        .s1_pix  (s1_pix),
        .win     (win),
        .s2_ctl  (s2_ctl)
    );

    gblur_mac u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .s2_ctl      (s2_ctl),
        .win         (win),
        .coef_center (center_reg),
        .coef_edge   (edge_reg),
        .coef_corner (corner_reg),
        .res_valid   (res_valid),
        .res_pixel   (res_pixel),
        .res_last    (res_last)
    );

    gblur_ofifo u_ofifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .reserve     (accept && due),
        .push        (res_valid),
        .push_pixel  (res_pixel),
        .push_last   (res_last),
        .out_stall   (out_stall),
        .credit_full (credit_full),
        .out_valid   (out_valid),
        .pixel_out   (pixel_out),
        .frame_last  (frame_last)
    );

endmodule

[hdl/gblur_chk.sv]
// Port-level checker for the Gaussian blur top level and its bind statement.
module gblur_chk import gblur_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [PIX_W-1:0] pixel_out,
    input logic             frame_last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_out) && $stable(frame_last))
        else $error("Stalled output request changed or was dropped.");

    a_out_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pixel_out <= SAT_LIMIT)
        else $error("Output pixel exceeds the saturation limit.");

    a_stall_backed: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("Input stalled while no output request is offered.");

endmodule

bind gaussian_blur_3x3_stream_top gblur_chk u_gblur_chk (.*);
